FILE: design/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared word types, operation codes and the SHA-1 constants.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0]  chain_t;
    typedef word_t [15:0] block_t;

    // Operation codes on the input channel
    localparam logic [1:0] OP_APPEND   = 2'd0;
    localparam logic [1:0] OP_FINALIZE = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Padding marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Index of the final digest word
    localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

    // Round constants, one per group of twenty rounds
    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    // Initial chaining values, H0 at index 0
    localparam chain_t INIT_CHAIN = '{
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Last round of the 80-round compression
    localparam logic [6:0] LAST_ROUND = 7'd79;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

FILE: design/sbsh_round_core.sv
// ----------------------------------------------------------------------------
// SHA-1 round core
// One compression round per cycle, with a 16-word rolling message schedule;
// adds the chaining input back in once the rounds finish.
// ----------------------------------------------------------------------------
module sbsh_round_core
    import sbsh_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  chain_t h_in,
    input  block_t blk_in,
    output logic   done,
    output chain_t h_out
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_DONE = 3'b100
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [6:0]  round_reg;
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    block_t      w_reg;
    word_t       f_val, k_val, t_val, w_new;

    // Select the round function and constant by round group
    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
        t_val = rotl(a_reg, 5) + f_val + e_reg + w_reg[0] + k_val;
        w_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    end

    // Sequence the rounds
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE: begin
                if (start) begin
                    state_next = C_RUN;
                end
            end
            C_RUN: begin
                if (round_reg == LAST_ROUND) begin
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Load working variables, then advance one round a cycle
    always_ff @(posedge aclk) begin
        if (state_reg == C_IDLE && start) begin
            a_reg     <= h_in[0];
            b_reg     <= h_in[1];
            c_reg     <= h_in[2];
            d_reg     <= h_in[3];
            e_reg     <= h_in[4];
            w_reg     <= blk_in;
            round_reg <= '0;
        end else if (state_reg == C_RUN) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
            round_reg <= round_reg + 7'd1;
        end
    end

    assign done     = (state_reg == C_DONE);
    assign h_out[0] = h_in[0] + a_reg;
    assign h_out[1] = h_in[1] + b_reg;
    assign h_out[2] = h_in[2] + c_reg;
    assign h_out[3] = h_in[3] + d_reg;
    assign h_out[4] = h_in[4] + e_reg;

endmodule

FILE: design/sha1_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Packs message bytes into 64-byte blocks, compresses each full block and
// emits the padded digest on request without disturbing the running state.
// ----------------------------------------------------------------------------
//  Channel  Ports                                 Direction  Moves
//  s_       op, data_byte                         in         one command
//  m_       digest_word, word_index, status, last out        one digest word
//
//  An append stores its byte and returns to idle; the byte that fills a block
//  goes through accept, load, the rounds on the shared round core, final add.
//  A finalize compresses one padded block before its first result transaction,
//  or two when the padding spills into a second block, then 5 result transactions;
//  with the length error set it goes straight to a single result transaction.
//  Reset loads the initial chaining values and clears count and error.
//  The input side is not ready while a block or the digest is in progress;
//  result transactions hold until m_ready.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit
    import sbsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_status,
    output logic        m_last
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_BLK_GO   = 8'b0000_0010,
        S_BLK_RUN  = 8'b0000_0100,
        S_FIN1_GO  = 8'b0000_1000,
        S_FIN1_RUN = 8'b0001_0000,
        S_FIN2_GO  = 8'b0010_0000,
        S_FIN2_RUN = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    chain_t      chain_reg;
    chain_t      scratch_reg;
    block_t      block_reg;
    logic [5:0]  idx_reg;
    logic [63:0] bitlen_reg;
    logic        err_reg;
    logic [2:0]  emit_idx_reg;
    logic        emit_err_reg;

    logic        accept;
    logic        len_full;
    logic        two_blocks;
    logic        emit_last;
    logic        core_start;
    logic        core_done;
    chain_t      core_h_in;
    chain_t      core_h_out;
    block_t      core_blk;
    block_t      pad1;
    block_t      pad2;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign len_full   = &bitlen_reg[63:3];
    assign two_blocks = (idx_reg > 6'd55);
    assign emit_last  = emit_err_reg || (emit_idx_reg == LAST_WORD_INDEX);

    // Build the padded final blocks from the pending bytes
    always_comb begin
        logic [5:0] pos;
        for (int j = 0; j < 16; j++) begin
            for (int l = 0; l < 4; l++) begin
                pos = 6'(j * 4 + l);
                if (pos < idx_reg) begin
                    pad1[j][31 - 8 * l -: 8] = block_reg[j][31 - 8 * l -: 8];
                end else if (pos == idx_reg) begin
                    pad1[j][31 - 8 * l -: 8] = PAD_BYTE;
                end else begin
                    pad1[j][31 - 8 * l -: 8] = 8'h00;
                end
            end
        end
        if (!two_blocks) begin
            pad1[14] = bitlen_reg[63:32];
            pad1[15] = bitlen_reg[31:0];
        end
        pad2     = '0;
        pad2[14] = bitlen_reg[63:32];
        pad2[15] = bitlen_reg[31:0];
    end

    // Steer the round core inputs
    always_comb begin
        core_start = 1'b0;
        core_blk   = block_reg;
        core_h_in  = scratch_reg;
        case (state_reg)
            S_BLK_GO: begin
                core_start = 1'b1;
                core_h_in  = chain_reg;
            end
            S_BLK_RUN: begin
                core_h_in = chain_reg;
            end
            S_FIN1_GO: begin
                core_start = 1'b1;
                core_blk   = pad1;
            end
            S_FIN2_GO: begin
                core_start = 1'b1;
                core_blk   = pad2;
            end
            default: begin
                core_start = 1'b0;
            end
        endcase
    end

    sbsh_round_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .h_in    (core_h_in),
        .blk_in  (core_blk),
        .done    (core_done),
        .h_out   (core_h_out)
    );

    // Sequence commands, compressions and result transactions
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_op == OP_APPEND && !err_reg && !len_full
                        && idx_reg == 6'd63) begin
                        state_next = S_BLK_GO;
                    end else if (s_op == OP_FINALIZE) begin
                        state_next = err_reg ? S_EMIT : S_FIN1_GO;
                    end
                end
            end
            S_BLK_GO:   state_next = S_BLK_RUN;
            S_BLK_RUN: begin
                if (core_done) begin
                    state_next = S_IDLE;
                end
            end
            S_FIN1_GO:  state_next = S_FIN1_RUN;
            S_FIN1_RUN: begin
                if (core_done) begin
                    state_next = two_blocks ? S_FIN2_GO : S_EMIT;
                end
            end
            S_FIN2_GO:  state_next = S_FIN2_RUN;
            S_FIN2_RUN: begin
                if (core_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_ready && emit_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state: chaining words, count, error and emit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            chain_reg    <= INIT_CHAIN;
            idx_reg      <= '0;
            bitlen_reg   <= '0;
            err_reg      <= 1'b0;
            emit_idx_reg <= '0;
            emit_err_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                case (s_op)
                    OP_APPEND: begin
                        if (!err_reg) begin
                            if (len_full) begin
                                err_reg <= 1'b1;
                            end else begin
                                idx_reg    <= idx_reg + 6'd1;
                                bitlen_reg <= bitlen_reg + 64'd8;
                            end
                        end
                    end
                    OP_FINALIZE: begin
                        emit_idx_reg <= '0;
                        emit_err_reg <= err_reg;
                    end
                    OP_RESTART: begin
                        chain_reg  <= INIT_CHAIN;
                        idx_reg    <= '0;
                        bitlen_reg <= '0;
                        err_reg    <= 1'b0;
                    end
                    default: begin
                        err_reg <= err_reg;
                    end
                endcase
            end
            if (state_reg == S_BLK_RUN && core_done) begin
                chain_reg <= core_h_out;
            end
            if (state_reg == S_EMIT && m_ready && !emit_last) begin
                emit_idx_reg <= emit_idx_reg + 3'd1;
            end
        end
    end

    // Store message bytes big-endian and the scratch digest
    always_ff @(posedge aclk) begin
        if (accept && s_op == OP_APPEND && !err_reg && !len_full) begin
            block_reg[idx_reg[5:2]][{~idx_reg[1:0], 3'b000} +: 8] <= s_data_byte;
        end
        if (accept && s_op == OP_FINALIZE) begin
            scratch_reg <= chain_reg;
        end else if ((state_reg == S_FIN1_RUN || state_reg == S_FIN2_RUN)
                     && core_done) begin
            scratch_reg <= core_h_out;
        end
    end

    // Drive the result transaction from the scratch digest
    assign m_valid       = (state_reg == S_EMIT);
    assign m_digest_word = emit_err_reg ? 32'd0 : scratch_reg[emit_idx_reg];
    assign m_word_index  = emit_err_reg ? 3'd0 : emit_idx_reg;
    assign m_status      = emit_err_reg ? STATUS_ERR : STATUS_OK;
    assign m_last        = emit_last;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Drives command transactions (append, finalize, restart, unused code) with
// random gaps and result back-pressure. A scoreboard keeps its own copy of the
// chaining words, block buffer, pending count and bit length, predicts the
// digest words of every finalize and checks each result transaction in order.
// ----------------------------------------------------------------------------
module tb_top
    import sbsh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Command code that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       status;
        logic       last;
    } digest_beat_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow hash state and queue of digest words still owed
    // ------------------------------------------------------------------------
    class sha1_digest_scoreboard;
        chain_t       chain;
        block_t       blk;
        int           fill;
        logic [63:0]  nbits;
        bit           too_long;
        digest_beat_t expected_words[$];
        int           errors;
        int           n_cmds;
        int           n_finalize;
        int           n_spill;
        int           n_checked;

        function new();
            errors     = 0;
            n_cmds     = 0;
            n_finalize = 0;
            n_spill    = 0;
            n_checked  = 0;
            restart_msg();
        endfunction

        function void restart_msg();
            chain    = INIT_CHAIN;
            blk      = '0;
            fill     = 0;
            nbits    = '0;
            too_long = 1'b0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function word_t rot_left(word_t x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // Place one byte big-endian within its word
        function block_t put_byte(block_t m, int pos, logic [7:0] v);
            m[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = v;
            return m;
        endfunction

        // 80-round compression of one block onto the chaining words
        function chain_t compress_block(chain_t h, block_t m);
            word_t w [80];
            word_t a, b, c, d, e, f, t, k;
            int    i;
            for (i = 0; i < 16; i++) w[i] = m[i];
            for (i = 16; i < 80; i++)
                w[i] = rot_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
            for (i = 0; i < 80; i++) begin
                case (i / 20)
                    0: begin
                        f = (b & c) | (~b & d);
                        k = K_0;
                    end
                    1: begin
                        f = b ^ c ^ d;
                        k = K_1;
                    end
                    2: begin
                        f = (b & c) | (b & d) | (c & d);
                        k = K_2;
                    end
                    default: begin
                        f = b ^ c ^ d;
                        k = K_3;
                    end
                endcase
                t = rot_left(a, 5) + f + e + w[i] + k;
                e = d;
                d = c;
                c = rot_left(b, 30);
                b = a;
                a = t;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
            return h;
        endfunction

        // Pad a scratch copy and queue the five digest words
        function void queue_digest();
            chain_t       h;
            block_t       m;
            int           p;
            int           k;
            digest_beat_t beat;
            h = chain;
            m = put_byte(blk, fill, PAD_BYTE);
            p = fill + 1;
            if (p > 56) begin
                n_spill++;
                while (p < 64) begin
                    m = put_byte(m, p, 8'h00);
                    p++;
                end
                h = compress_block(h, m);
                p = 0;
            end
            while (p < 56) begin
                m = put_byte(m, p, 8'h00);
                p++;
            end
            m[14] = nbits[63:32];
            m[15] = nbits[31:0];
            h = compress_block(h, m);
            for (k = 0; k < 5; k++) begin
                beat.word   = h[k];
                beat.index  = 3'(k);
                beat.status = STATUS_OK;
                beat.last   = (3'(k) == LAST_WORD_INDEX);
                expected_words.push_back(beat);
            end
        endfunction

        // Advance the shadow state by one accepted command transaction
        function void note_command(logic [1:0] op, logic [7:0] data);
            digest_beat_t beat;
            n_cmds++;
            case (op)
                OP_APPEND: begin
                    if (!too_long) begin
                        if (&nbits[63:3]) begin
                            too_long = 1'b1;
                        end else begin
                            blk = put_byte(blk, fill, data);
                            fill++;
                            nbits += 64'd8;
                            if (fill == 64) begin
                                chain = compress_block(chain, blk);
                                fill  = 0;
                            end
                        end
                    end
                end
                OP_FINALIZE: begin
                    n_finalize++;
                    if (too_long) begin
                        beat.word   = '0;
                        beat.index  = '0;
                        beat.status = STATUS_ERR;
                        beat.last   = 1'b1;
                        expected_words.push_back(beat);
                    end else begin
                        queue_digest();
                    end
                end
                OP_RESTART: restart_msg();
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
        endtask

        // Compare one result transaction with the oldest owed word
        task check_word(word_t word, logic [2:0] index, logic status, logic last);
            digest_beat_t exp_beat;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected result word %h index %0d", word, index));
                return;
            end
            exp_beat = expected_words.pop_front();
            n_checked++;
            if (word !== exp_beat.word)
                report($sformatf("digest word %h, expected %h", word, exp_beat.word));
            if (index !== exp_beat.index)
                report($sformatf("word index %0d, expected %0d", index, exp_beat.index));
            if (status !== exp_beat.status)
                report($sformatf("status %b, expected %b", status, exp_beat.status));
            if (last !== exp_beat.last)
                report($sformatf("last %b, expected %b", last, exp_beat.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_status;
    logic        m_last;

    bit                    steady;
    sha1_digest_scoreboard sb;

    sha1_byte_stream_hasher_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one command transaction and hold it until accepted
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] data);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op        = op;
        s_data_byte = data;
        s_valid     = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_command(op, data);
        @(negedge aclk);
    endtask

    // Hold off the sender until every owed digest word has come back
    task automatic hold_until_drained();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // Result side back-pressure, changed at the falling edge
    initial begin
        int stall;
        int r;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (steady) begin
                m_ready = 1'b1;
            end else if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready = 1'b1;
                end else begin
                    m_ready = 1'b0;
                    stall   = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Check each result transaction at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_digest_word, m_word_index, m_status, m_last);
    end

    // Stimulus
    initial begin
        int items;
        int len;
        int i;
        int r;
        sb          = new();
        steady      = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = OP_APPEND;
        s_data_byte = 8'h00;
        m_ready     = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty message, byte extremes, ignored code, restart, "abc"
        send_cmd(OP_FINALIZE, 8'hFF);
        hold_until_drained();
        send_cmd(OP_APPEND, 8'h00);
        send_cmd(OP_APPEND, 8'hFF);
        send_cmd(OP_FINALIZE, 8'h00);
        send_cmd(OP_UNUSED, 8'hAA);
        send_cmd(OP_UNUSED, 8'h55);
        send_cmd(OP_FINALIZE, 8'h00);
        send_cmd(OP_RESTART, 8'h55);
        send_cmd(OP_APPEND, 8'h61);
        send_cmd(OP_APPEND, 8'h62);
        send_cmd(OP_APPEND, 8'h63);
        send_cmd(OP_FINALIZE, 8'hAA);
        send_cmd(OP_APPEND, 8'h80);
        send_cmd(OP_FINALIZE, 8'h00);
        send_cmd(OP_RESTART, 8'hAA);
        send_cmd(OP_FINALIZE, 8'h00);

        // Random messages: varied lengths, boundary lengths, mid-stream digests
        items = 0;
        while (items < 200) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) == 0) begin
                send_cmd(OP_RESTART, 8'($urandom));
                items++;
            end
            r = $urandom_range(0, 11);
            case (r)
                0:       len = 55;
                1:       len = 56;
                2:       len = 63;
                3:       len = 64;
                default: len = $urandom_range(0, 12);
            endcase
            for (i = 0; i < len; i++) begin
                send_cmd(OP_APPEND, 8'($urandom));
                items++;
                if ($urandom_range(0, 19) == 0) begin
                    send_cmd(OP_FINALIZE, 8'($urandom));
                    items++;
                end
                if ($urandom_range(0, 39) == 0)
                    send_cmd(OP_UNUSED, 8'($urandom));
            end
            send_cmd(OP_FINALIZE, 8'($urandom));
            items++;
            if ($urandom_range(0, 5) == 0) hold_until_drained();
        end
        steady  = 1'b0;
        s_valid = 1'b0;

        // Drain, then allow for the longest internal pass
        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d digest words never arrived", sb.pending()));

        $display("Covered %0d commands and %0d finalizes (%0d spilling into a second block).",
                 sb.n_cmds, sb.n_finalize, sb.n_spill);
        $display("Checked %0d digest result transactions, %0d mismatches.",
                 sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
